// ===== rtl/owm_pkg.sv =====
// shared types, codes and constants of the 1-wire temperature sensor reader
// no dependencies; imported by owm_step and onewire_temp_sensor_reader
`default_nettype none

package owm_pkg;

    // scratchpad bytes read by a read request (byte index is 4 bits wide)
    localparam int unsigned SCRATCH_BYTES = 9;

    // 1-wire command bytes
    localparam logic [7:0] CMD_SKIP_ROM  = 8'hCC;
    localparam logic [7:0] CMD_READ_PAD  = 8'hBE;
    localparam logic [7:0] CMD_CONVERT_T = 8'h44;
    localparam logic [7:0] READ_FILL     = 8'hFF;
    localparam logic [7:0] CRC_POLY_REFL = 8'h8C;

    // register reset values
    localparam logic [9:0] RESET_LOW_DEFAULT     = 10'd480;
    localparam logic [9:0] PRESENCE_WAIT_DEFAULT = 10'd66;
    localparam logic [5:0] SAMPLE_POINT_DEFAULT  = 6'd15;
    localparam logic [6:0] SLOT_TIME_DEFAULT     = 7'd60;

    typedef enum logic [1:0] {
        REG_RESET_LOW     = 2'd0,
        REG_PRESENCE_WAIT = 2'd1,
        REG_SAMPLE_POINT  = 2'd2,
        REG_SLOT_TIME     = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_START = 2'd1,
        MODE_READ  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BUS_BUSY = 2'd1,
        ST_CRC_ERR  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_RST_LOW  = 3'd1,
        PH_RST_WAIT = 3'd2,
        PH_WR_SKIP  = 3'd3,
        PH_WR_CMD   = 3'd4,
        PH_READ     = 3'd5
    } t_phase;

    typedef struct packed {
        logic [1:0] mode;
        logic       line_level;
        logic       power_extern;
    } t_owm_in;

    typedef struct packed {
        logic        pull_low;
        logic        strong_pullup;
        logic        busy_res;
        logic        done_res;
        logic [1:0]  status;
        logic [15:0] measurement;
    } t_owm_out;

    typedef struct packed {
        logic [9:0] reset_low_time;
        logic [9:0] presence_wait;
        logic [5:0] sample_point;
        logic [6:0] slot_time;
    } t_owm_cfg;

    typedef struct packed {
        t_phase      phase;
        logic [9:0]  tick_count;
        logic [7:0]  shift_byte;
        logic [2:0]  bit_index;
        logic [3:0]  byte_index;
        logic [7:0]  crc_reg;
        logic [15:0] temp_word;
        logic        request_kind;  // 0 start, 1 read
        logic        extern_power;
        logic        pullup_on;
        logic        slot_sample;
    } t_owm_state;

    // reflected crc-8, one byte lsb first
    function automatic logic [7:0] owm_crc8(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] c;
        logic [7:0] d;
        logic       mix;
        c = crc_in;
        d = data;
        for (int i = 0; i < 8; i++) begin
            mix = c[0] ^ d[0];
            c   = {1'b0, c[7:1]};
            if (mix) begin
                c = c ^ CRC_POLY_REFL;
            end
            d = {1'b0, d[7:1]};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/owm_step.sv =====
// one item step of the 1-wire master: request handling, tick timing, slots, crc
// depends on owm_pkg (types, command bytes, crc function)
`default_nettype none

module owm_step (
    input  owm_pkg::t_owm_state i_state,
    input  owm_pkg::t_owm_in    i_in,
    input  owm_pkg::t_owm_cfg   i_cfg,
    output owm_pkg::t_owm_state o_state,
    output owm_pkg::t_owm_out   o_res
);
    import owm_pkg::*;

    t_owm_state st_a;
    t_owm_state st_n;
    logic       is_req;
    logic [6:0] slot_len;
    logic [5:0] samp_lo;
    logic [6:0] samp_tick;
    logic [9:0] low_len;
    logic [9:0] wait_max;
    logic [9:0] wait_len;
    logic [9:0] tc_inc;
    logic       slot_end;
    logic       smp;
    logic [7:0] shift_new;
    logic [2:0] bi_inc;
    logic [3:0] bx_inc;
    logic [7:0] crc_new;
    logic       done;
    t_status    status;
    logic [15:0] meas;

    function automatic t_owm_state begin_byte(input t_owm_state s, input t_phase p,
                                              input logic [7:0] v);
        t_owm_state r;
        r             = s;
        r.phase       = p;
        r.shift_byte  = v;
        r.bit_index   = '0;
        r.tick_count  = '0;
        r.slot_sample = 1'b0;
        return r;
    endfunction

    // timing derived from the registers
    always_comb begin
        slot_len  = (i_cfg.slot_time < 7'd2) ? 7'd2 : i_cfg.slot_time;
        samp_lo   = (i_cfg.sample_point == 6'd0) ? 6'd1 : i_cfg.sample_point;
        samp_tick = ({1'b0, samp_lo} > slot_len - 7'd1) ? slot_len - 7'd1 : {1'b0, samp_lo};
        low_len   = (i_cfg.reset_low_time == 10'd0) ? 10'd1 : i_cfg.reset_low_time;
        wait_max  = (i_cfg.reset_low_time > i_cfg.presence_wait) ? i_cfg.reset_low_time
                                                                  : i_cfg.presence_wait;
        wait_len  = (wait_max == 10'd0) ? 10'd1 : wait_max;
    end

    // request acceptance when idle
    always_comb begin
        st_a   = i_state;
        is_req = (i_in.mode == MODE_START) || (i_in.mode == MODE_READ);
        if (is_req && (i_state.phase == PH_IDLE)) begin
            st_a.request_kind = (i_in.mode == MODE_READ);
            if (i_in.mode == MODE_START) begin
                st_a.extern_power = i_in.power_extern;
            end
            st_a.pullup_on  = 1'b0;
            st_a.phase      = PH_RST_LOW;
            st_a.tick_count = '0;
        end
    end

    // slot datapath
    always_comb begin
        tc_inc    = st_a.tick_count + 10'd1;
        slot_end  = ({1'b0, st_a.tick_count} + 11'd1) >= {4'b0, slot_len};
        smp       = (st_a.tick_count == {3'b0, samp_tick})
                    ? (st_a.shift_byte[0] & i_in.line_level) : st_a.slot_sample;
        shift_new = {smp, st_a.shift_byte[7:1]};
        bi_inc    = st_a.bit_index + 3'd1;
        bx_inc    = st_a.byte_index + 4'd1;
        crc_new   = owm_crc8(st_a.crc_reg, shift_new);
    end

    // next state
    always_comb begin
        st_n   = st_a;
        done   = 1'b0;
        status = ST_OK;
        meas   = '0;
        if (i_in.mode == MODE_TICK) begin
            unique case (st_a.phase)
                PH_RST_LOW: begin
                    if ((tc_inc == 10'd0) || (tc_inc >= low_len)) begin
                        st_n.phase      = PH_RST_WAIT;
                        st_n.tick_count = '0;
                    end else begin
                        st_n.tick_count = tc_inc;
                    end
                end
                PH_RST_WAIT: begin
                    if ((tc_inc == 10'd0) || (tc_inc >= wait_len)) begin
                        if (!st_a.request_kind && !i_in.line_level) begin
                            st_n.phase      = PH_IDLE;
                            st_n.tick_count = '0;
                            done            = 1'b1;
                            status          = ST_BUS_BUSY;
                        end else begin
                            st_n = begin_byte(st_a, PH_WR_SKIP, CMD_SKIP_ROM);
                        end
                    end else begin
                        st_n.tick_count = tc_inc;
                    end
                end
                PH_WR_SKIP, PH_WR_CMD, PH_READ: begin
                    st_n.slot_sample = smp;
                    if (slot_end) begin
                        st_n.shift_byte  = shift_new;
                        st_n.slot_sample = 1'b0;
                        st_n.tick_count  = '0;
                        st_n.bit_index   = bi_inc;
                        if (bi_inc == 3'd0) begin
                            priority if (st_a.phase == PH_WR_SKIP) begin
                                st_n = begin_byte(st_n, PH_WR_CMD,
                                    st_a.request_kind ? CMD_READ_PAD : CMD_CONVERT_T);
                            end else if (st_a.phase == PH_WR_CMD) begin
                                if (!st_a.request_kind) begin
                                    st_n.phase     = PH_IDLE;
                                    done           = 1'b1;
                                    st_n.pullup_on = !st_a.extern_power;
                                end else begin
                                    st_n.byte_index = '0;
                                    st_n.crc_reg    = '0;
                                    st_n = begin_byte(st_n, PH_READ, READ_FILL);
                                end
                            end else begin
                                st_n.crc_reg = crc_new;
                                if (st_a.byte_index == 4'd0) begin
                                    st_n.temp_word[7:0] = shift_new;
                                end else if (st_a.byte_index == 4'd1) begin
                                    st_n.temp_word[15:8] = shift_new;
                                end
                                st_n.byte_index = bx_inc;
                                if ((bx_inc >= 4'(SCRATCH_BYTES)) || (bx_inc == 4'd0)) begin
                                    st_n.phase = PH_IDLE;
                                    done       = 1'b1;
                                    if (crc_new != 8'd0) begin
                                        status = ST_CRC_ERR;
                                    end else begin
                                        meas = st_n.temp_word;
                                    end
                                end else begin
                                    st_n = begin_byte(st_n, PH_READ, READ_FILL);
                                end
                            end
                        end
                    end else begin
                        st_n.tick_count = tc_inc;
                    end
                end
                default: begin
                    st_n.phase = PH_IDLE;
                end
            endcase
        end
    end

    // result of the item: drive for this tick, status after it
    always_comb begin
        o_state             = st_n;
        o_res.strong_pullup = st_a.pullup_on;
        unique case (st_a.phase)
            PH_RST_LOW: o_res.pull_low = 1'b1;
            PH_WR_SKIP, PH_WR_CMD, PH_READ:
                o_res.pull_low = (st_a.tick_count == 10'd0) || !st_a.shift_byte[0];
            default: o_res.pull_low = 1'b0;
        endcase
        o_res.busy_res    = (st_n.phase != PH_IDLE);
        o_res.done_res    = done;
        o_res.status      = status;
        o_res.measurement = meas;
    end

endmodule

`default_nettype wire

// ===== rtl/onewire_temp_sensor_reader.sv =====
// top level of the 1-wire temperature sensor reader: apb registers, state, result stage
// depends on owm_pkg and owm_step
//
// usage:
//  - input channel (i_in_valid / o_in_stall / i_in_data) carries one item per
//    transfer: a microsecond tick with the sampled line level, a start
//    conversion request or a read measurement request
//  - output channel (o_out_valid / i_out_stall / o_out_data) returns exactly
//    one result per input transfer, in order: line drive for that tick,
//    busy, done, status and the measurement word
//  - results are registered: the result of an item accepted at one edge is
//    valid after that edge; one item per cycle is taken while the receiver
//    keeps up, the whole step being a single pass through owm_step
//  - when the receiver stalls with a result pending, o_in_stall rises in the
//    same cycle and the result register holds until the transfer completes
//  - apb port writes the four timing registers (byte addresses 0, 4, 8, 12);
//    write only while the block is idle; pready is always high
//  - synchronous reset returns the sequencer to idle, clears the pull-up and
//    loads the default timing of 480, 66, 15 and 60 microseconds
`default_nettype none

module onewire_temp_sensor_reader (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // item input
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  owm_pkg::t_owm_in     i_in_data,
    // result output
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output owm_pkg::t_owm_out    o_out_data,
    // register port
    input  wire                  psel,
    input  wire                  penable,
    input  wire                  pwrite,
    input  wire  [3:0]           paddr,
    input  wire  [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import owm_pkg::*;

    t_owm_cfg   r_cfg;
    t_owm_state r_state;
    t_owm_state n_state;
    t_owm_out   n_res;
    t_owm_out   r_res;
    logic       r_out_valid;
    logic       in_xfer;
    logic       out_xfer;
    logic       cfg_wr;
    t_reg_idx   reg_idx;

    assign pready   = 1'b1;
    assign reg_idx  = t_reg_idx'(paddr[3:2]);
    assign cfg_wr   = psel && penable && pwrite && pready;

    // result register frees up when empty or being taken this cycle
    assign out_xfer   = r_out_valid && !i_out_stall;
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_xfer    = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_res;

    // register readback
    always_comb begin
        unique case (reg_idx)
            REG_RESET_LOW:     prdata = {22'b0, r_cfg.reset_low_time};
            REG_PRESENCE_WAIT: prdata = {22'b0, r_cfg.presence_wait};
            REG_SAMPLE_POINT:  prdata = {26'b0, r_cfg.sample_point};
            REG_SLOT_TIME:     prdata = {25'b0, r_cfg.slot_time};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low_time <= RESET_LOW_DEFAULT;
            r_cfg.presence_wait  <= PRESENCE_WAIT_DEFAULT;
            r_cfg.sample_point   <= SAMPLE_POINT_DEFAULT;
            r_cfg.slot_time      <= SLOT_TIME_DEFAULT;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_RESET_LOW:     r_cfg.reset_low_time <= pwdata[9:0];
                REG_PRESENCE_WAIT: r_cfg.presence_wait  <= pwdata[9:0];
                REG_SAMPLE_POINT:  r_cfg.sample_point   <= pwdata[5:0];
                REG_SLOT_TIME:     r_cfg.slot_time      <= pwdata[6:0];
            endcase
        end
    end

    // one step of the sequencer per accepted item
    owm_step u_step (
        .i_state (r_state),
        .i_in    (i_in_data),
        .i_cfg   (r_cfg),
        .o_state (n_state),
        .o_res   (n_res)
    );

    // sequencer state, advanced only on an input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_IDLE, default: '0};
        end else if (in_xfer) begin
            r_state <= n_state;
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_res <= n_res;
        end
    end

    // a finished sequence leaves the block idle
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.done_res) |-> !r_res.busy_res)
        else $error("done result still reports busy");

    // status is only reported on the finishing item
    a_status_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_res.status != ST_OK)) |-> r_res.done_res)
        else $error("status set without done");

    // measurement only on a clean finish
    a_meas_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_res.measurement != 16'd0)) |->
            (r_res.done_res && (r_res.status == ST_OK)))
        else $error("measurement without successful read");

    // every input transfer produces a result in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> o_out_valid)
        else $error("accepted item produced no result");

endmodule

`default_nettype wire

// ===== tb/onewire_temp_sensor_reader_tb.sv =====
// self-checking testbench for onewire_temp_sensor_reader: conversions, scratchpad reads,
// idle-check failures and apb timing registers, with its own model of the bus master
// depends on owm_pkg and the rtl of the block only
`timescale 1ns / 1ps

module onewire_temp_sensor_reader_tb;
    import owm_pkg::*;

    // mode value with no meaning, the block must ignore it
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int IDLE_PCT = 21;
    localparam int RANDOM_ITEMS = 1800;
    localparam int unsigned CYCLE_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_owm_in     i_in_data;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_owm_out    o_out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    onewire_temp_sensor_reader dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // model of the bus master: timing registers and sequencer state
    t_owm_cfg    timing;
    t_phase      bus_phase;
    logic [9:0]  bus_ticks;
    logic [7:0]  bus_shift;
    logic [2:0]  bus_bit;
    logic [3:0]  bus_byte;
    logic [7:0]  bus_crc;
    logic [15:0] bus_temp;
    logic        bus_is_read;
    logic        bus_ext_power;
    logic        bus_pullup;
    logic        bus_sample;

    // scratchpad the emulated sensor answers with
    logic [7:0]  scratch_image [0:15];

    // line drive and status the block should report, oldest first
    t_owm_out    bus_outcomes [$];

    bit          no_idling = 1'b0;
    int          mismatches = 0;
    int          items_sent = 0;
    int          results_checked = 0;
    int          register_writes = 0;
    int          conversions = 0;
    int          good_reads = 0;
    int          crc_faults = 0;
    int          bus_faults = 0;
    int unsigned cycle_count = 0;

    // clock, 10 ns period
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- timing helpers

    // slot length, never below two ticks
    function automatic int slot_ticks();
        return (timing.slot_time < 7'd2) ? 2 : int'(timing.slot_time);
    endfunction

    // sample tick, clamped into the slot
    function automatic int sample_at();
        int s;
        s = (timing.sample_point < 6'd1) ? 1 : int'(timing.sample_point);
        return (s > slot_ticks() - 1) ? slot_ticks() - 1 : s;
    endfunction

    function automatic int low_ticks();
        return (timing.reset_low_time == '0) ? 1 : int'(timing.reset_low_time);
    endfunction

    // release after the reset pulse lasts the longer of the two settings
    function automatic int release_ticks();
        int w;
        w = (timing.reset_low_time > timing.presence_wait) ? int'(timing.reset_low_time)
                                                           : int'(timing.presence_wait);
        return (w == 0) ? 1 : w;
    endfunction

    // line held low during the reset pulse, on slot tick 0 and for the whole of a 0 bit
    function automatic logic line_driven_low();
        if (bus_phase == PH_RST_LOW) begin
            return 1'b1;
        end
        if (bus_phase == PH_WR_SKIP || bus_phase == PH_WR_CMD || bus_phase == PH_READ) begin
            return (bus_ticks == '0) || !bus_shift[0];
        end
        return 1'b0;
    endfunction

    // reflected crc-8 over one byte, lsb first
    function automatic logic [7:0] crc_after_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc;
        for (int k = 0; k < 8; k++) begin
            c = (c[0] ^ data[k]) ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
        end
        return c;
    endfunction

    function automatic void load_byte(input t_phase next_phase, input logic [7:0] value);
        bus_phase  = next_phase;
        bus_shift  = value;
        bus_bit    = '0;
        bus_ticks  = '0;
        bus_sample = 1'b0;
    endfunction

    // ---------------------------------------------------------------- bus master model

    // advances the model by one item and returns the result it should give
    function automatic t_owm_out step_bus_master(input t_owm_in item);
        t_owm_out res;
        res = '0;
        if (item.mode != MODE_TICK) begin
            // requests take effect at once when idle; anything else is ignored
            if (bus_phase == PH_IDLE && (item.mode == MODE_START || item.mode == MODE_READ)) begin
                bus_is_read = (item.mode == MODE_READ);
                if (item.mode == MODE_START) begin
                    bus_ext_power = item.power_extern;
                end
                bus_pullup = 1'b0;
                bus_phase  = PH_RST_LOW;
                bus_ticks  = '0;
            end
            res.pull_low      = line_driven_low();
            res.strong_pullup = bus_pullup;
        end else begin
            // drive shown is the one applied during this tick
            res.pull_low      = line_driven_low();
            res.strong_pullup = bus_pullup;
            case (bus_phase)
                PH_RST_LOW: begin
                    bus_ticks = bus_ticks + 10'd1;
                    if (bus_ticks == '0 || int'(bus_ticks) >= low_ticks()) begin
                        bus_phase = PH_RST_WAIT;
                        bus_ticks = '0;
                    end
                end
                PH_RST_WAIT: begin
                    bus_ticks = bus_ticks + 10'd1;
                    if (bus_ticks == '0 || int'(bus_ticks) >= release_ticks()) begin
                        // idle check on the last released tick, for conversions only
                        if (!bus_is_read && !item.line_level) begin
                            bus_phase    = PH_IDLE;
                            bus_ticks    = '0;
                            res.done_res = 1'b1;
                            res.status   = ST_BUS_BUSY;
                            bus_faults++;
                        end else begin
                            load_byte(PH_WR_SKIP, CMD_SKIP_ROM);
                        end
                    end
                end
                PH_WR_SKIP, PH_WR_CMD, PH_READ: begin
                    if (int'(bus_ticks) == sample_at()) begin
                        bus_sample = bus_shift[0] & item.line_level;
                    end
                    if (int'(bus_ticks) + 1 >= slot_ticks()) begin
                        bus_shift  = {bus_sample, bus_shift[7:1]};
                        bus_sample = 1'b0;
                        bus_ticks  = '0;
                        bus_bit    = bus_bit + 3'd1;
                        if (bus_bit == 3'd0) begin
                            if (bus_phase == PH_WR_SKIP) begin
                                load_byte(PH_WR_CMD, bus_is_read ? CMD_READ_PAD : CMD_CONVERT_T);
                            end else if (bus_phase == PH_WR_CMD) begin
                                if (!bus_is_read) begin
                                    // conversion started; parasite power gets the pull-up
                                    bus_phase    = PH_IDLE;
                                    res.done_res = 1'b1;
                                    bus_pullup   = !bus_ext_power;
                                    conversions++;
                                end else begin
                                    bus_byte = '0;
                                    bus_crc  = '0;
                                    load_byte(PH_READ, READ_FILL);
                                end
                            end else begin
                                bus_crc = crc_after_byte(bus_crc, bus_shift);
                                if (bus_byte == 4'd0) begin
                                    bus_temp[7:0] = bus_shift;
                                end else if (bus_byte == 4'd1) begin
                                    bus_temp[15:8] = bus_shift;
                                end
                                bus_byte = bus_byte + 4'd1;
                                if (bus_byte >= 4'(SCRATCH_BYTES) || bus_byte == 4'd0) begin
                                    bus_phase    = PH_IDLE;
                                    res.done_res = 1'b1;
                                    if (bus_crc != '0) begin
                                        res.status = ST_CRC_ERR;
                                        crc_faults++;
                                    end else begin
                                        res.measurement = bus_temp;
                                        good_reads++;
                                    end
                                end else begin
                                    load_byte(PH_READ, READ_FILL);
                                end
                            end
                        end
                    end else begin
                        bus_ticks = bus_ticks + 10'd1;
                    end
                end
                default: begin
                    bus_phase = PH_IDLE;
                end
            endcase
        end
        res.busy_res = (bus_phase != PH_IDLE);
        return res;
    endfunction

    // emulated sensor: scratchpad bit at the sample tick of a read slot, the chosen
    // level on the last released tick after reset, noise everywhere else
    function automatic logic sensor_line(input logic idle_high);
        if (bus_phase == PH_READ && int'(bus_ticks) == sample_at()) begin
            return scratch_image[bus_byte][bus_bit];
        end
        if (bus_phase == PH_RST_WAIT && int'(bus_ticks) + 1 >= release_ticks()) begin
            return idle_high;
        end
        return $urandom_range(1) != 0;
    endfunction

    // ---------------------------------------------------------------- drivers

    // one item over the input channel; the model steps when the transfer happens
    task automatic send_item(input logic [1:0] mode, input logic line, input logic pwr);
        t_owm_in item;
        item.mode         = mode;
        item.line_level   = line;
        item.power_extern = pwr;
        while (!no_idling && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        bus_outcomes.push_back(step_bus_master(item));
        items_sent++;
    endtask

    // stop sending and let every outstanding result arrive
    task automatic settle();
        i_in_valid <= 1'b0;
        while (bus_outcomes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (2) @(posedge i_clk);
    endtask

    // apb write, then read back over the same selection
    task automatic write_register(input t_reg_idx idx, input logic [31:0] value);
        logic [31:0] got;
        logic [31:0] want;
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        case (idx)
            REG_RESET_LOW:     timing.reset_low_time = value[9:0];
            REG_PRESENCE_WAIT: timing.presence_wait  = value[9:0];
            REG_SAMPLE_POINT:  timing.sample_point   = value[5:0];
            default:           timing.slot_time      = value[6:0];
        endcase
        register_writes++;
        // read setup follows straight on
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        got = prdata;
        case (idx)
            REG_RESET_LOW:     want = {22'd0, timing.reset_low_time};
            REG_PRESENCE_WAIT: want = {22'd0, timing.presence_wait};
            REG_SAMPLE_POINT:  want = {26'd0, timing.sample_point};
            default:           want = {25'd0, timing.slot_time};
        endcase
        if (got !== want) begin
            $error("prdata mismatch at %0h: expected %0h, got %0h", {idx, 2'b00}, want, got);
            mismatches++;
        end
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_timing(input int low, input int wait_us, input int sample, input int slot);
        write_register(REG_RESET_LOW, low);
        write_register(REG_PRESENCE_WAIT, wait_us);
        write_register(REG_SAMPLE_POINT, sample);
        write_register(REG_SLOT_TIME, slot);
    endtask

    // a whole conversion or read: the request, then ticks until the sequencer is idle;
    // busy_noise is the share of requests and unused modes slipped in while busy
    task automatic run_sequence(input bit is_read, input bit pwr, input bit idle_high,
                                input bit crc_good, input int busy_noise);
        logic [7:0] crc;
        logic [1:0] mode;
        int         fb;
        int         fi;
        crc = '0;
        for (int k = 0; k < SCRATCH_BYTES - 1; k++) begin
            scratch_image[k] = 8'($urandom_range(255));
            crc = crc_after_byte(crc, scratch_image[k]);
        end
        // trailing crc byte makes the whole pad check to zero
        scratch_image[SCRATCH_BYTES - 1] = crc;
        if (!crc_good) begin
            fb = $urandom_range(SCRATCH_BYTES - 1);
            fi = $urandom_range(7);
            scratch_image[fb][fi] = ~scratch_image[fb][fi];
        end
        send_item(is_read ? MODE_READ : MODE_START, $urandom_range(1) != 0, pwr);
        while (bus_phase != PH_IDLE) begin
            if ($urandom_range(99) < busy_noise) begin
                case ($urandom_range(2))
                    0:       mode = MODE_START;
                    1:       mode = MODE_READ;
                    default: mode = MODE_UNUSED;
                endcase
                send_item(mode, $urandom_range(1) != 0, $urandom_range(1) != 0);
            end else begin
                send_item(MODE_TICK, sensor_line(idle_high), $urandom_range(1) != 0);
            end
        end
    endtask

    // ---------------------------------------------------------------- tests

    // items while idle, then a parasite conversion at the reset timing
    task automatic test_idle_and_defaults();
        send_item(MODE_TICK, 1'b0, 1'b0);
        send_item(MODE_TICK, 1'b1, 1'b1);
        send_item(MODE_UNUSED, 1'b1, 1'b0);
        send_item(MODE_UNUSED, 1'b0, 1'b1);
        run_sequence(1'b0, 1'b0, 1'b1, 1'b1, 0);
        // pull-up now on, seen on idle ticks and unused modes
        send_item(MODE_TICK, 1'b0, 1'b1);
        send_item(MODE_UNUSED, 1'b1, 1'b0);
        settle();
    endtask

    task automatic test_start_requests();
        set_timing(3, 5, 4, 8);
        run_sequence(1'b0, 1'b0, 1'b1, 1'b1, 0);
        repeat (3) send_item(MODE_TICK, $urandom_range(1) != 0, $urandom_range(1) != 0);
        // external power: request clears the pull-up, none afterwards; requests while busy
        run_sequence(1'b0, 1'b1, 1'b1, 1'b1, 25);
        send_item(MODE_TICK, 1'b1, 1'b0);
        // line low at the idle check aborts a conversion
        run_sequence(1'b0, 1'b0, 1'b0, 1'b1, 0);
        run_sequence(1'b0, 1'b1, 1'b0, 1'b1, 10);
        settle();
    endtask

    task automatic test_read_requests();
        // presence wait longer than the pulse; sample point beyond the slot is clamped
        set_timing(2, 9, 63, 8);
        run_sequence(1'b1, 1'b0, 1'b1, 1'b1, 0);
        // idle check does not matter for a read; corrupted pad gives a crc error
        run_sequence(1'b1, 1'b1, 1'b0, 1'b0, 10);
        write_register(REG_SAMPLE_POINT, 2);
        write_register(REG_SLOT_TIME, 9);
        run_sequence(1'b1, 1'b0, 1'b1, 1'b1, 0);
        settle();
    endtask

    task automatic test_timing_extremes();
        set_timing(1, 1, 2, 8);
        run_sequence(1'b0, 1'b0, 1'b1, 1'b1, 0);
        run_sequence(1'b1, 1'b1, 1'b1, 1'b1, 5);
        set_timing(1023, 1023, 63, 127);
        run_sequence(1'b0, 1'b0, 1'b1, 1'b1, 2);
        settle();
    endtask

    // mostly well-formed sequences under changing timing, with idle noise between them
    task automatic test_random_traffic();
        int base;
        int seq;
        base      = items_sent;
        seq       = 0;
        no_idling = 1'b1;
        while (items_sent - base < RANDOM_ITEMS) begin
            if (seq % 3 == 0) begin
                set_timing($urandom_range(1, 40), $urandom_range(1, 40),
                           $urandom_range(2, 63), $urandom_range(8, 10));
            end
            if ($urandom_range(99) < 25) begin
                repeat ($urandom_range(1, 6)) begin
                    send_item($urandom_range(1) != 0 ? MODE_TICK : MODE_UNUSED,
                              $urandom_range(1) != 0, $urandom_range(1) != 0);
                end
            end else begin
                run_sequence($urandom_range(99) < 35, $urandom_range(1) != 0,
                             $urandom_range(99) < 85, $urandom_range(99) < 75, 4);
            end
            seq++;
            // no idling on either side at the start, then both sides idle at random
            if (items_sent - base > 500) begin
                no_idling = 1'b0;
            end
        end
        no_idling = 1'b0;
        settle();
    endtask

    // ---------------------------------------------------------------- result side

    // receiver stalls at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= !no_idling && ($urandom_range(99) < IDLE_PCT);
        end
    end

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // every result transfer against the oldest outstanding expectation
    always @(posedge i_clk) begin : check_results
        t_owm_out want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (bus_outcomes.size() == 0) begin
                $error("result transfer with nothing outstanding: %0h", o_out_data);
                mismatches++;
            end else begin
                want = bus_outcomes.pop_front();
                compare_field("pull_low", 16'(want.pull_low), 16'(o_out_data.pull_low));
                compare_field("strong_pullup", 16'(want.strong_pullup),
                              16'(o_out_data.strong_pullup));
                compare_field("busy_res", 16'(want.busy_res), 16'(o_out_data.busy_res));
                compare_field("done_res", 16'(want.done_res), 16'(o_out_data.done_res));
                compare_field("status", 16'(want.status), 16'(o_out_data.status));
                compare_field("measurement", want.measurement, o_out_data.measurement);
                results_checked++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("onewire_temp_sensor_reader_tb failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence of tests

    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        // model starts from the reset state
        timing.reset_low_time = RESET_LOW_DEFAULT;
        timing.presence_wait  = PRESENCE_WAIT_DEFAULT;
        timing.sample_point   = SAMPLE_POINT_DEFAULT;
        timing.slot_time      = SLOT_TIME_DEFAULT;
        bus_phase     = PH_IDLE;
        bus_ticks     = '0;
        bus_shift     = '0;
        bus_bit       = '0;
        bus_byte      = '0;
        bus_crc       = '0;
        bus_temp      = '0;
        bus_is_read   = 1'b0;
        bus_ext_power = 1'b0;
        bus_pullup    = 1'b0;
        bus_sample    = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_and_defaults();
        test_start_requests();
        test_read_requests();
        test_timing_extremes();
        test_random_traffic();

        repeat (8) @(posedge i_clk);
        if (bus_outcomes.size() != 0) begin
            $error("%0d results never arrived", bus_outcomes.size());
            mismatches++;
        end
        $display("%0d items sent, %0d results compared, %0d register writes with read-back",
                 items_sent, results_checked, register_writes);
        $display("%0d conversions, %0d clean reads, %0d crc errors, %0d bus-not-idle aborts",
                 conversions, good_reads, crc_faults, bus_faults);
        if (mismatches == 0) begin
            $display("onewire_temp_sensor_reader_tb passed");
        end else begin
            $display("onewire_temp_sensor_reader_tb failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/owm_pkg.sv
rtl/owm_step.sv
rtl/onewire_temp_sensor_reader.sv
tb/onewire_temp_sensor_reader_tb.sv
